// ===== sv/la32r_dec_pkg.sv =====
// Types, codes and the instruction pattern table for the LA32R decoder.
// No dependencies; imported by la32r_instruction_decoder.
package la32r_dec_pkg;

  localparam int NumPat = 61;

  typedef enum logic [1:0] {
    FaultOk        = 2'd0,
    FaultMisalign  = 2'd1,
    FaultUserHigh  = 2'd2,
    FaultInvalid   = 2'd3
  } fault_e;

  typedef enum logic [3:0] {
    FmtNone      = 4'd0,
    FmtR3        = 4'd1,
    FmtR2I12     = 4'd2,
    FmtR2I12U    = 4'd3,
    FmtR1I20     = 4'd4,
    FmtR2I8      = 4'd5,
    FmtR2I14     = 4'd6,
    FmtR2I14S    = 4'd7,
    FmtR2I16     = 4'd8,
    FmtI26       = 4'd9,
    FmtCode15    = 4'd10,
    FmtBl        = 4'd11,
    FmtPcaddu12i = 4'd12,
    FmtJirl      = 4'd13,
    FmtCacop     = 4'd14
  } fmt_e;

  // stores and preld carry an rd field that is not a destination
  localparam logic [5:0] IdStB  = 6'd29;
  localparam logic [5:0] IdStH  = 6'd30;
  localparam logic [5:0] IdStW  = 6'd31;
  localparam logic [5:0] IdPreld = 6'd32;

  localparam logic [1:0]  PlvUser      = 2'd3;
  localparam logic [31:0] LinkOffset   = 32'd4;

  localparam logic [31:0] M17  = 32'hFFFF8000;
  localparam logic [31:0] M10  = 32'hFFC00000;
  localparam logic [31:0] M8   = 32'hFF000000;
  localparam logic [31:0] M7   = 32'hFE000000;
  localparam logic [31:0] M6   = 32'hFC000000;
  localparam logic [31:0] MAll = 32'hFFFFFFFF;
  localparam logic [31:0] MI14 = 32'hFF0003E0;

  localparam logic [31:0] PatMask [NumPat] = '{
    M17, M17, M17, M17, M17, M17, M17, M17, M17, M17,
    M17, M17, M17, M17, M17, M17, M17, M17,
    M7, M7,
    M10, M10, M10, M10, M10, M10, M10, M10, M10, M10, M10, M10, M10,
    M10, M10, M10,
    M17, M17, M17,
    M6, M6, M6, M6, M6, M6, M6, M6, M6,
    MI14, MI14, M8,
    M8, M8,
    M17, M17, M17,
    MAll, M17, M17, MAll, MAll
  };

  localparam logic [31:0] PatMatch [NumPat] = '{
    32'h00100000, 32'h00110000, 32'h00120000, 32'h00128000, 32'h00140000,
    32'h00148000, 32'h00150000, 32'h00158000, 32'h001C0000, 32'h001C8000,
    32'h001D0000, 32'h00200000, 32'h00210000, 32'h00208000, 32'h00218000,
    32'h00170000, 32'h00178000, 32'h00180000,
    32'h14000000, 32'h1C000000,
    32'h02800000, 32'h02000000, 32'h02400000, 32'h06000000, 32'h28000000,
    32'h28400000, 32'h28800000, 32'h2A000000, 32'h2A400000, 32'h29000000,
    32'h29400000, 32'h29800000, 32'h2AC00000,
    32'h03400000, 32'h03800000, 32'h03C00000,
    32'h00408000, 32'h00448000, 32'h00488000,
    32'h58000000, 32'h5C000000, 32'h60000000, 32'h64000000, 32'h68000000,
    32'h6C000000, 32'h4C000000, 32'h50000000, 32'h54000000,
    32'h04000000, 32'h04000020, 32'h04000000,
    32'h20000000, 32'h21000000,
    32'h002B0000, 32'h002A0000, 32'h06488000,
    32'h06483800, 32'h38720000, 32'h38728000, 32'h80000000, 32'hC0000000
  };

  localparam fmt_e PatFmt [NumPat] = '{
    FmtR3, FmtR3, FmtR3, FmtR3, FmtR3, FmtR3, FmtR3, FmtR3, FmtR3, FmtR3,
    FmtR3, FmtR3, FmtR3, FmtR3, FmtR3, FmtR3, FmtR3, FmtR3,
    FmtR1I20, FmtPcaddu12i,
    FmtR2I12, FmtR2I12, FmtR2I12, FmtCacop, FmtR2I12, FmtR2I12, FmtR2I12,
    FmtR2I12, FmtR2I12, FmtR2I12, FmtR2I12, FmtR2I12, FmtR2I12,
    FmtR2I12U, FmtR2I12U, FmtR2I12U,
    FmtR2I8, FmtR2I8, FmtR2I8,
    FmtR2I16, FmtR2I16, FmtR2I16, FmtR2I16, FmtR2I16, FmtR2I16,
    FmtJirl, FmtI26, FmtBl,
    FmtR2I14, FmtR2I14, FmtR2I14,
    FmtR2I14S, FmtR2I14S,
    FmtCode15, FmtCode15, FmtCode15,
    FmtNone, FmtNone, FmtNone, FmtNone, FmtNone
  };

  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] fetch_pc;
    logic [1:0]  privilege_level;
  } dec_in_t;

  typedef struct packed {
    fault_e      fault;
    logic [5:0]  instr_id;
    fmt_e        format;
    logic [4:0]  rd_index;
    logic [4:0]  rj_index;
    logic [4:0]  rk_index;
    logic [31:0] immediate;
    logic [31:0] link_addr;
    logic        dest_write_en;
  } dec_out_t;

endpackage

// ===== sv/la32r_instruction_decoder.sv =====
// LA32R instruction decoder: input register, pattern match and operand
// extraction, result register. Depends on la32r_dec_pkg.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one fetched instruction with
//   its pc and privilege level per transaction. Output channel
//   out_valid_o/out_ready_i returns exactly one decode result per input, in
//   order: fault code, instruction id, format, register fields, immediate
//   (or pc-relative target), pc+4 and the destination write enable.
//   A transaction is held in the input register; the decode table lookup and
//   the single immediate/target adder sit between it and the result register,
//   which drives out_valid_o and out_data_o.
//   Throughput is one transaction per cycle while out_ready_i is high.
//   When the receiver stalls, the result register holds its transaction and
//   the input register still takes one more; in_ready_o drops only when both
//   stages are full and out_ready_i is low.
//   Reset (rst_ni low, asynchronous) empties both stages; no state survives
//   between transactions, so nothing else is cleared.
module la32r_instruction_decoder
  import la32r_dec_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dec_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dec_out_t out_data_o
);

  logic     in_valid_q;
  dec_in_t  in_data_q;
  logic     out_valid_q;
  dec_out_t out_data_q;
  logic     advance;
  dec_out_t dec_d;

  logic [NumPat-1:0] hit;
  logic              any_hit;
  logic [5:0]        id;
  fmt_e              fmt;
  logic [31:0]       w;
  logic [31:0]       pc;
  logic [31:0]       add_a;
  logic [31:0]       add_b;
  logic [31:0]       imm;
  logic              writes;
  logic [4:0]        rd;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  assign w  = in_data_q.instr_word;
  assign pc = in_data_q.fetch_pc;

  // first matching pattern wins
  always_comb begin
    id = '0;
    for (int i = 0; i < NumPat; i++) begin
      hit[i] = (w & PatMask[i]) == PatMatch[i];
    end
    for (int i = NumPat - 1; i >= 0; i--) begin
      if (hit[i]) begin
        id = 6'(i);
      end
    end
    any_hit = |hit;
    fmt     = any_hit ? PatFmt[id] : FmtNone;
  end

  always_comb begin
    add_a  = '0;
    add_b  = '0;
    writes = 1'b0;
    rd     = w[4:0];
    unique case (fmt)
      FmtR3: begin
        writes = 1'b1;
      end
      FmtR2I12: begin
        add_b  = {{20{w[21]}}, w[21:10]};
        writes = !(id == IdStB || id == IdStH || id == IdStW || id == IdPreld);
      end
      FmtCacop: begin
        add_b = {{20{w[21]}}, w[21:10]};
      end
      FmtR2I12U: begin
        add_b  = {20'd0, w[21:10]};
        writes = 1'b1;
      end
      FmtR1I20: begin
        add_b  = {w[24:5], 12'd0};
        writes = 1'b1;
      end
      FmtPcaddu12i: begin
        add_a  = pc;
        add_b  = {w[24:5], 12'd0};
        writes = 1'b1;
      end
      FmtR2I8: begin
        add_b  = {27'd0, w[14:10]};
        writes = 1'b1;
      end
      FmtR2I14: begin
        add_b  = {18'd0, w[23:10]};
        writes = 1'b1;
      end
      FmtR2I14S: begin
        add_b  = {{18{w[23]}}, w[23:10]};
        writes = 1'b1;
      end
      FmtR2I16: begin
        add_a = pc;
        add_b = {{14{w[25]}}, w[25:10], 2'b00};
      end
      FmtJirl: begin
        add_b  = {{14{w[25]}}, w[25:10], 2'b00};
        writes = 1'b1;
      end
      FmtI26: begin
        add_a = pc;
        add_b = {{4{w[9]}}, w[9:0], w[25:10], 2'b00};
      end
      FmtBl: begin
        add_a  = pc;
        add_b  = {{4{w[9]}}, w[9:0], w[25:10], 2'b00};
        rd     = 5'd1;
        writes = 1'b1;
      end
      FmtCode15: begin
        add_b = {17'd0, w[14:0]};
      end
      default: begin
      end
    endcase
    imm = add_a + add_b;
  end

  always_comb begin
    dec_d = '0;
    priority if (pc[1:0] != 2'b00) begin
      dec_d.fault = FaultMisalign;
    end else if (in_data_q.privilege_level == PlvUser && pc[31]) begin
      dec_d.fault = FaultUserHigh;
    end else if (!any_hit) begin
      dec_d.fault = FaultInvalid;
    end else begin
      dec_d.fault         = FaultOk;
      dec_d.instr_id      = id;
      dec_d.format        = fmt;
      dec_d.rd_index      = rd;
      dec_d.rj_index      = w[9:5];
      dec_d.rk_index      = w[14:10];
      dec_d.immediate     = imm;
      dec_d.link_addr     = pc + LinkOffset;
      dec_d.dest_write_en = writes && (rd != 5'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (advance && in_valid_q) begin
      out_data_q <= dec_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // back-pressure only when both stages hold a transaction
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_o && !out_ready_i))
    else $error("input stalled while a stage is free");

  a_fault_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.fault != FaultOk) |->
      (out_data_o.immediate == '0 && out_data_o.instr_id == '0 &&
       out_data_o.link_addr == '0 && !out_data_o.dest_write_en))
    else $error("faulting transaction carries decode fields");

  a_no_r0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.dest_write_en) |-> (out_data_o.rd_index != 5'd0))
    else $error("write enable set for r0");

  a_bl_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.fault == FaultOk && out_data_o.format == FmtBl) |->
      (out_data_o.rd_index == 5'd1 && out_data_o.dest_write_en))
    else $error("bl without link to r1");

endmodule

// ===== test/la32r_instruction_decoder_tb.sv =====
// Self-checking testbench for la32r_instruction_decoder: directed and random fetches go
// through the input channel, and each decode result is checked against a local decode model.
// Depends on la32r_dec_pkg and la32r_instruction_decoder.
module la32r_instruction_decoder_tb;
  import la32r_dec_pkg::*;

  localparam int NumOps = 61;
  localparam int RandomFetches = 1826;
  localparam int TailFetches = 150;
  localparam int DrainCycles = 10;
  localparam int CycleLimit = 200000;

  localparam logic [31:0] Op3R = 32'hFFFF8000;
  localparam logic [31:0] OpI12 = 32'hFFC00000;
  localparam logic [31:0] OpI14 = 32'hFF000000;
  localparam logic [31:0] OpI20 = 32'hFE000000;
  localparam logic [31:0] OpBr = 32'hFC000000;
  localparam logic [31:0] OpFull = 32'hFFFFFFFF;
  localparam logic [31:0] OpCsr = 32'hFF0003E0;

  localparam logic [31:0] OpMask [NumOps] = '{
    Op3R, Op3R, Op3R, Op3R, Op3R, Op3R, Op3R, Op3R, Op3R, Op3R,
    Op3R, Op3R, Op3R, Op3R, Op3R, Op3R, Op3R, Op3R,
    OpI20, OpI20,
    OpI12, OpI12, OpI12, OpI12, OpI12, OpI12, OpI12, OpI12, OpI12, OpI12,
    OpI12, OpI12, OpI12, OpI12, OpI12, OpI12,
    Op3R, Op3R, Op3R,
    OpBr, OpBr, OpBr, OpBr, OpBr, OpBr, OpBr, OpBr, OpBr,
    OpCsr, OpCsr, OpI14, OpI14, OpI14,
    Op3R, Op3R, Op3R,
    OpFull, Op3R, Op3R, OpFull, OpFull
  };

  localparam logic [31:0] OpMatch [NumOps] = '{
    32'h00100000, 32'h00110000, 32'h00120000, 32'h00128000, 32'h00140000,
    32'h00148000, 32'h00150000, 32'h00158000, 32'h001C0000, 32'h001C8000,
    32'h001D0000, 32'h00200000, 32'h00210000, 32'h00208000, 32'h00218000,
    32'h00170000, 32'h00178000, 32'h00180000,
    32'h14000000, 32'h1C000000,
    32'h02800000, 32'h02000000, 32'h02400000, 32'h06000000, 32'h28000000,
    32'h28400000, 32'h28800000, 32'h2A000000, 32'h2A400000, 32'h29000000,
    32'h29400000, 32'h29800000, 32'h2AC00000,
    32'h03400000, 32'h03800000, 32'h03C00000,
    32'h00408000, 32'h00448000, 32'h00488000,
    32'h58000000, 32'h5C000000, 32'h60000000, 32'h64000000, 32'h68000000,
    32'h6C000000, 32'h4C000000, 32'h50000000, 32'h54000000,
    32'h04000000, 32'h04000020, 32'h04000000, 32'h20000000, 32'h21000000,
    32'h002B0000, 32'h002A0000, 32'h06488000,
    32'h06483800, 32'h38720000, 32'h38728000, 32'h80000000, 32'hC0000000
  };

  localparam fmt_e OpFmt [NumOps] = '{
    FmtR3, FmtR3, FmtR3, FmtR3, FmtR3, FmtR3, FmtR3, FmtR3, FmtR3, FmtR3,
    FmtR3, FmtR3, FmtR3, FmtR3, FmtR3, FmtR3, FmtR3, FmtR3,
    FmtR1I20, FmtPcaddu12i,
    FmtR2I12, FmtR2I12, FmtR2I12, FmtCacop, FmtR2I12, FmtR2I12, FmtR2I12,
    FmtR2I12, FmtR2I12, FmtR2I12, FmtR2I12, FmtR2I12, FmtR2I12,
    FmtR2I12U, FmtR2I12U, FmtR2I12U,
    FmtR2I8, FmtR2I8, FmtR2I8,
    FmtR2I16, FmtR2I16, FmtR2I16, FmtR2I16, FmtR2I16, FmtR2I16,
    FmtJirl, FmtI26, FmtBl,
    FmtR2I14, FmtR2I14, FmtR2I14, FmtR2I14S, FmtR2I14S,
    FmtCode15, FmtCode15, FmtCode15,
    FmtNone, FmtNone, FmtNone, FmtNone, FmtNone
  };

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  dec_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  dec_out_t out_data;

  dec_in_t  fetch_queue[$];
  dec_out_t pending_decodes[$];
  dec_out_t want_dec;
  int       send_gap = 0;
  int       stall_left = 0;
  int       cycle_cnt = 0;
  int       mismatches = 0;
  int       decodes_seen = 0;
  int       faults_seen = 0;
  logic [63:0] ids_hit = '0;

  la32r_instruction_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  function automatic dec_out_t decode_fetch(dec_in_t f);
    dec_out_t    d;
    logic [31:0] w;
    logic [31:0] pc;
    logic        writes;
    int          hit;
    int          i;
    d = '0;
    w = f.instr_word;
    pc = f.fetch_pc;
    writes = 1'b0;
    hit = -1;
    if (pc[1:0] != 2'b00) begin
      d.fault = FaultMisalign;
      return d;
    end
    if (f.privilege_level == PlvUser && pc[31]) begin
      d.fault = FaultUserHigh;
      return d;
    end
    // first match in table order wins
    for (i = NumOps - 1; i >= 0; i--) begin
      if ((w & OpMask[i]) == OpMatch[i]) hit = i;
    end
    if (hit < 0) begin
      d.fault = FaultInvalid;
      return d;
    end
    d.fault = FaultOk;
    d.instr_id = 6'(hit);
    d.format = OpFmt[hit];
    d.rd_index = w[4:0];
    d.rj_index = w[9:5];
    d.rk_index = w[14:10];
    d.link_addr = pc + 32'd4;
    case (d.format)
      FmtR3: begin
        writes = 1'b1;
      end
      FmtR2I12: begin
        d.immediate = {{20{w[21]}}, w[21:10]};
        writes = !(d.instr_id == IdStB || d.instr_id == IdStH ||
                   d.instr_id == IdStW || d.instr_id == IdPreld);
      end
      FmtCacop: begin
        d.immediate = {{20{w[21]}}, w[21:10]};
      end
      FmtR2I12U: begin
        d.immediate = {20'd0, w[21:10]};
        writes = 1'b1;
      end
      FmtR1I20: begin
        d.immediate = {w[24:5], 12'd0};
        writes = 1'b1;
      end
      FmtPcaddu12i: begin
        d.immediate = {w[24:5], 12'd0} + pc;
        writes = 1'b1;
      end
      FmtR2I8: begin
        d.immediate = {27'd0, w[14:10]};
        writes = 1'b1;
      end
      FmtR2I14: begin
        d.immediate = {18'd0, w[23:10]};
        writes = 1'b1;
      end
      FmtR2I14S: begin
        d.immediate = {{18{w[23]}}, w[23:10]};
        writes = 1'b1;
      end
      FmtR2I16: begin
        d.immediate = pc + {{14{w[25]}}, w[25:10], 2'b00};
      end
      FmtJirl: begin
        d.immediate = {{14{w[25]}}, w[25:10], 2'b00};
        writes = 1'b1;
      end
      FmtI26: begin
        d.immediate = pc + {{4{w[9]}}, w[9:0], w[25:10], 2'b00};
      end
      FmtBl: begin
        d.immediate = pc + {{4{w[9]}}, w[9:0], w[25:10], 2'b00};
        d.rd_index = 5'd1;
        writes = 1'b1;
      end
      FmtCode15: begin
        d.immediate = {17'd0, w[14:0]};
      end
      default: begin
      end
    endcase
    d.dest_write_en = writes && (d.rd_index != 5'd0);
    return d;
  endfunction

  function automatic bit bursts_allowed();
    // no idling in the tail; every third stretch of the queue runs flat out
    return fetch_queue.size() >= TailFetches && (fetch_queue.size() / 128) % 3 != 0;
  endfunction

  task automatic push_fetch(logic [31:0] word, logic [31:0] pc, logic [1:0] plv);
    dec_in_t f;
    f.instr_word = word;
    f.fetch_pc = pc;
    f.privilege_level = plv;
    fetch_queue.push_back(f);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d decodes outstanding", cycle_cnt,
               pending_decodes.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        pending_decodes.push_back(decode_fetch(in_data));
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (fetch_queue.size() != 0 &&
                   !(bursts_allowed() && $urandom_range(0, 7) == 0)) begin
        in_data <= fetch_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        if (fetch_queue.size() != 0) send_gap = $urandom_range(0, 9);
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        decodes_seen++;
        if (pending_decodes.size() == 0) begin
          $error("decode result with no transaction outstanding");
          mismatches++;
        end else begin
          want_dec = pending_decodes.pop_front();
          if (out_data.fault != want_dec.fault) begin
            $error("fault: expected %0d, got %0d", want_dec.fault, out_data.fault);
            mismatches++;
          end
          if (out_data.instr_id != want_dec.instr_id) begin
            $error("instr_id: expected %0d, got %0d", want_dec.instr_id, out_data.instr_id);
            mismatches++;
          end
          if (out_data.format != want_dec.format) begin
            $error("format: expected %0d, got %0d", want_dec.format, out_data.format);
            mismatches++;
          end
          if (out_data.rd_index != want_dec.rd_index) begin
            $error("rd_index: expected %0d, got %0d", want_dec.rd_index, out_data.rd_index);
            mismatches++;
          end
          if (out_data.rj_index != want_dec.rj_index) begin
            $error("rj_index: expected %0d, got %0d", want_dec.rj_index, out_data.rj_index);
            mismatches++;
          end
          if (out_data.rk_index != want_dec.rk_index) begin
            $error("rk_index: expected %0d, got %0d", want_dec.rk_index, out_data.rk_index);
            mismatches++;
          end
          if (out_data.immediate != want_dec.immediate) begin
            $error("immediate: expected %h, got %h", want_dec.immediate, out_data.immediate);
            mismatches++;
          end
          if (out_data.link_addr != want_dec.link_addr) begin
            $error("link_addr: expected %h, got %h", want_dec.link_addr, out_data.link_addr);
            mismatches++;
          end
          if (out_data.dest_write_en != want_dec.dest_write_en) begin
            $error("dest_write_en: expected %0d, got %0d", want_dec.dest_write_en,
                   out_data.dest_write_en);
            mismatches++;
          end
          if (want_dec.fault == FaultOk) ids_hit[want_dec.instr_id] = 1'b1;
          else faults_seen++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (bursts_allowed() && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    dec_in_t f;
    int      k;

    // fetch faults and their priority
    push_fetch(32'h00100000, 32'h80000001, PlvUser);
    push_fetch(32'h00000000, 32'hFFFFFFFE, 2'd0);
    push_fetch(32'h00000000, 32'h80000000, PlvUser);
    push_fetch(32'h00107FFF, 32'h7FFFFFFC, PlvUser);
    push_fetch(32'h00107FFF, 32'hFFFFFFFC, 2'd2);
    push_fetch(32'h00000000, 32'h00000000, 2'd0);
    push_fetch(32'hFFFFFFFF, 32'h00000000, 2'd0);
    push_fetch(32'h06483801, 32'h00000000, 2'd0);
    // r0 destination, pc+4 wrap
    push_fetch(32'h00100000, 32'hFFFFFFFC, 2'd0);
    // csrrd / csrwr win over csrxchg
    push_fetch(32'h04000005, 32'h00001000, 2'd0);
    push_fetch(32'h04000025, 32'h00001000, 2'd0);
    push_fetch(32'h04FFFFE5, 32'h00001000, 2'd0);
    // immediate extremes
    push_fetch(32'h02BFFC03, 32'h00000000, 2'd1);
    push_fetch(32'h029FFC03, 32'h00000000, 2'd1);
    push_fetch(32'h29800007, 32'h00000000, 2'd0);
    push_fetch(32'h2AC0001F, 32'h00000000, 2'd0);
    push_fetch(32'h063FFC1F, 32'h00000000, 2'd0);
    push_fetch(32'h15FFFFE1, 32'h00000000, 2'd0);
    push_fetch(32'h1DFFFFE1, 32'h00001000, 2'd0);
    push_fetch(32'h0040FFFF, 32'h00000000, 2'd0);
    push_fetch(32'h5A000000, 32'h00000000, 2'd0);
    push_fetch(32'h50000200, 32'h10000000, 2'd0);
    push_fetch(32'h57FFFFFF, 32'h00000000, 2'd0);
    push_fetch(32'h4DFFFC00, 32'h00000040, 2'd0);
    push_fetch(32'h002A7FFF, 32'h00000000, 2'd0);
    push_fetch(32'h06483800, 32'h00000000, 2'd0);
    push_fetch(32'h80000000, 32'h00000000, 2'd0);
    push_fetch(32'hC0000000, 32'h00000000, 2'd0);

    // mostly legal encodings with random fields, some raw noise
    for (int n = 0; n < RandomFetches; n++) begin
      f.instr_word = $urandom;
      f.fetch_pc = $urandom;
      f.privilege_level = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) != 0) begin
        k = $urandom_range(0, NumOps - 1);
        f.instr_word = (f.instr_word & ~OpMask[k]) | OpMatch[k];
        if ($urandom_range(0, 7) == 0) f.instr_word[4:0] = 5'd0;
        if ($urandom_range(0, 15) != 0) f.fetch_pc[1:0] = 2'b00;
        if (f.privilege_level == PlvUser && $urandom_range(0, 1) == 1) begin
          f.fetch_pc[31] = 1'b0;
        end
      end
      fetch_queue.push_back(f);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (fetch_queue.size() != 0 || in_valid || pending_decodes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("decoded %0d transactions, %0d of them faulting", decodes_seen, faults_seen);
    $display("%0d of %0d instruction ids hit, %0d mismatches", $countones(ids_hit), NumOps,
             mismatches);
    if (mismatches == 0 && pending_decodes.size() == 0 && !in_valid) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
